// ===== design/vhal_pkg.sv =====
// Package for the virtual host address lookup: field widths, operation codes,
// insert-count constants and the sequencer state type.
// No dependencies.
`default_nettype none

package vhal_pkg;

  localparam int OP_W   = 2;
  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int SRV_W  = 8;
  localparam int CNT_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP   = 2'd0,
    OP_INS_ADDR = 2'd1,
    OP_INS_DFLT = 2'd2
  } op_e;

  // insert count saturates; two or more inserts mark an entry name-based
  localparam logic [CNT_W-1:0] CNT_NEW    = 2'd1;
  localparam logic [CNT_W-1:0] CNT_SHARED = 2'd2;
  localparam logic [CNT_W-1:0] CNT_MAX    = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FOLD,
    ST_HEAD,
    ST_SEEK,
    ST_WALK
  } state_e;

endpackage

`default_nettype wire

// ===== design/vhal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vhal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/vhal_fold.sv =====
// Bucket hash unit: XOR-folds an IPv4 address and reduces it modulo BUCKETS.
// Depends on vhal_pkg. Power-of-two bucket counts register the masked fold; others use a
// reciprocal multiply pipelined through partial products, quotient and remainder.
`default_nettype none

module vhal_fold #(
  parameter int BUCKETS = 256,
  localparam int BW = $clog2(BUCKETS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [vhal_pkg::ADDR_W-1:0] addr_i,
  output logic                        done_o,
  output logic [BW-1:0]               bucket_o
);

  localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

  logic [vhal_pkg::ADDR_W-1:0] half_x;
  logic [vhal_pkg::ADDR_W-1:0] fold_x;

  assign half_x = addr_i ^ (addr_i >> 16);
  assign fold_x = half_x ^ (half_x >> 8);

  if (POW2) begin : g_mask
    logic          done_q;
    logic [BW-1:0] bkt_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        bkt_q <= fold_x[BW-1:0];
      end
    end

    assign done_o   = done_q;
    assign bucket_o = bkt_q;
  end else begin : g_rcp
    // ceil(2^(32+BW) / BUCKETS) gives the exact quotient for any 32-bit value
    localparam int unsigned SH = vhal_pkg::ADDR_W + BW;
    localparam longint unsigned RCP =
      ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [15:0] RCP_LO = 16'(RCP);
    localparam logic [17:0] RCP_HI = 18'(RCP >> 16);

    logic                        done_q;
    logic [2:0]                  stage_q;
    logic [vhal_pkg::ADDR_W-1:0] x_q;
    logic [47:0]                 plo_q;
    logic [49:0]                 phi_q;
    logic [vhal_pkg::ADDR_W-1:0] q_q;
    logic [BW-1:0]               bkt_q;
    logic [65:0]                 prod;
    logic [65:0]                 quo;
    logic [vhal_pkg::ADDR_W-1:0] qb;
    logic [vhal_pkg::ADDR_W-1:0] rem;

    // product split in two halves of the reciprocal; the registered halves are summed combinationally
    assign prod = {phi_q, 16'd0} + {18'd0, plo_q};
    assign quo  = prod >> SH;
    assign qb   = q_q * vhal_pkg::ADDR_W'(BUCKETS);
    assign rem  = x_q - qb;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stage_q <= '0;
        done_q  <= 1'b0;
      end else begin
        stage_q <= {stage_q[1:0], start_i};
        done_q  <= stage_q[2];
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        x_q <= fold_x;
      end
      if (stage_q[0]) begin
        plo_q <= x_q * RCP_LO;
        phi_q <= x_q * RCP_HI;
      end
      if (stage_q[1]) begin
        q_q <= quo[vhal_pkg::ADDR_W-1:0];
      end
      if (stage_q[2]) begin
        bkt_q <= rem[BW-1:0];
      end
    end

    assign done_o   = done_q;
    assign bucket_o = bkt_q;
  end

endmodule

`default_nettype wire

// ===== design/virtual_host_address_lookup.sv =====
// Virtual host address lookup: chained hash table of address/port entries
// plus a wildcard default chain. Depends on vhal_pkg, vhal_ram, vhal_fold.
//
//   channel  | ports                                         | handshake
//   ---------+-----------------------------------------------+-----------------------
//   command  | operation_i address_i port_i server_id_i      | start high, busy low
//   result   | found_o matched_server_o name_based_o         | done_o, one cycle
//            | from_default_o status_o                       |
//
// A lookup or addressed insert passes the hash fold, a bucket head read and a seek,
// then walks the bucket chain; a lookup that falls through to the default chain
// seeks again and walks the default entries. A default insert skips the head read.
// The chain walk reads one entry per cycle from the entry RAM's single read port.
// A bucket count that is not a power of two adds the reciprocal remainder stages.
// After reset a clearing pass writes every bucket head, with busy high.
// The receiver cannot stall; each result is flagged by done_o for exactly one cycle.
`default_nettype none

module virtual_host_address_lookup #(
  parameter int BUCKETS = 256,
  parameter int ENTRIES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [vhal_pkg::OP_W-1:0]   operation_i,
  input  logic [vhal_pkg::ADDR_W-1:0] address_i,
  input  logic [vhal_pkg::PORT_W-1:0] port_i,
  input  logic [vhal_pkg::SRV_W-1:0]  server_id_i,
  output logic                        done_o,
  output logic                        found_o,
  output logic [vhal_pkg::SRV_W-1:0]  matched_server_o,
  output logic                        name_based_o,
  output logic                        from_default_o,
  output logic                        status_o
);

  localparam int BW = $clog2(BUCKETS);
  localparam int IW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] EMPTY = LW'(ENTRIES);

  typedef struct packed {
    logic [vhal_pkg::ADDR_W-1:0] addr;
    logic [vhal_pkg::PORT_W-1:0] port;
    logic [vhal_pkg::SRV_W-1:0]  srv;
    logic [LW-1:0]               nxt;
    logic [vhal_pkg::CNT_W-1:0]  cnt;
  } entry_t;

  localparam int EW = $bits(entry_t);

  vhal_pkg::state_e state_q, state_d;

  logic [vhal_pkg::OP_W-1:0]   op_q, op_d;
  logic [vhal_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [vhal_pkg::PORT_W-1:0] port_q, port_d;
  logic [vhal_pkg::SRV_W-1:0]  srv_q, srv_d;
  logic [LW-1:0]               head_q, head_d;
  logic [LW-1:0]               cur_q, cur_d;
  logic [LW-1:0]               dhead_q, dhead_d;
  logic [LW-1:0]               used_q, used_d;
  logic [BW-1:0]               clr_q, clr_d;
  logic                        in_dflt_q, in_dflt_d;
  logic                        wild_vld_q, wild_vld_d;
  logic [vhal_pkg::SRV_W-1:0]  wild_srv_q, wild_srv_d;
  logic [vhal_pkg::CNT_W-1:0]  wild_cnt_q, wild_cnt_d;

  logic                        done_q, done_d;
  logic                        found_q, found_d;
  logic [vhal_pkg::SRV_W-1:0]  res_srv_q, res_srv_d;
  logic                        nb_q, nb_d;
  logic                        dflt_q, dflt_d;
  logic                        status_q, status_d;

  // RAM and hash unit hookup
  logic          bkt_we, bkt_re;
  logic [BW-1:0] bkt_waddr;
  logic [LW-1:0] bkt_wdata, bkt_rdata;
  logic          ent_we, ent_re;
  logic [IW-1:0] ent_waddr, ent_raddr;
  entry_t        ent_wdata;
  logic [EW-1:0] ent_rdata;
  entry_t        ent;
  logic          fold_start, fold_done;
  logic [BW-1:0] bucket;

  // compare unit on the entry just read
  logic                       is_insert;
  logic                       in_walk, in_seek;
  logic                       cur_empty, nxt_empty;
  logic                       addr_eq, port_eq, eport_zero, qport_zero;
  logic                       exact, cand, hit;
  logic                       chain_end, wild_now, go_dflt, finish, full, do_add;
  logic [vhal_pkg::SRV_W-1:0] w_srv;
  logic [vhal_pkg::CNT_W-1:0] w_cnt, cnt_inc;

  vhal_ram #(
    .WIDTH (LW),
    .DEPTH (BUCKETS)
  ) u_bkt_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_waddr),
    .wdata_i (bkt_wdata),
    .re_i    (bkt_re),
    .raddr_i (bucket),
    .rdata_o (bkt_rdata)
  );

  vhal_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  vhal_fold #(
    .BUCKETS (BUCKETS)
  ) u_fold (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (fold_start),
    .addr_i   (address_i),
    .done_o   (fold_done),
    .bucket_o (bucket)
  );

  assign ent = entry_t'(ent_rdata);

  always_comb begin
    case (op_q) inside
      vhal_pkg::OP_INS_ADDR, vhal_pkg::OP_INS_DFLT: is_insert = 1'b1;
      vhal_pkg::OP_LOOKUP:                          is_insert = 1'b0;
      default:                                      is_insert = 1'b0;
    endcase
  end

  assign in_walk    = state_q == vhal_pkg::ST_WALK;
  assign in_seek    = state_q == vhal_pkg::ST_SEEK;
  assign cur_empty  = cur_q == EMPTY;
  assign nxt_empty  = ent.nxt == EMPTY;
  assign addr_eq    = ent.addr == addr_q;
  assign port_eq    = ent.port == port_q;
  assign eport_zero = ent.port == '0;
  assign qport_zero = port_q == '0;

  // default chain matches on port only; buckets on address and port
  assign exact = in_dflt_q ? port_eq : (addr_eq && port_eq);
  assign cand  = in_dflt_q ? eport_zero : (addr_eq && (eport_zero || qport_zero));
  assign hit   = in_walk && exact;

  assign chain_end = (in_seek && cur_empty) || (in_walk && !exact && nxt_empty);
  assign wild_now  = wild_vld_q || (in_walk && cand);
  assign w_srv     = wild_vld_q ? wild_srv_q : ent.srv;
  assign w_cnt     = wild_vld_q ? wild_cnt_q : ent.cnt;
  assign go_dflt   = chain_end && !is_insert && !in_dflt_q && !wild_now;
  assign finish    = hit || (chain_end && !go_dflt);
  assign full      = used_q == EMPTY;
  assign do_add    = chain_end && is_insert && !full;
  assign cnt_inc   = (ent.cnt == vhal_pkg::CNT_MAX) ? ent.cnt
                                                    : ent.cnt + vhal_pkg::CNT_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vhal_pkg::ST_CLEAR: begin
        if (clr_q == BW'(BUCKETS - 1)) begin
          state_d = vhal_pkg::ST_IDLE;
        end
      end
      vhal_pkg::ST_IDLE: begin
        if (start) begin
          state_d = vhal_pkg::ST_FOLD;
        end
      end
      vhal_pkg::ST_FOLD: begin
        if (fold_done) begin
          state_d = (op_q == vhal_pkg::OP_INS_DFLT) ? vhal_pkg::ST_SEEK
                                                    : vhal_pkg::ST_HEAD;
        end
      end
      vhal_pkg::ST_HEAD: begin
        state_d = vhal_pkg::ST_SEEK;
      end
      vhal_pkg::ST_SEEK: begin
        if (!cur_empty) begin
          state_d = vhal_pkg::ST_WALK;
        end else if (finish) begin
          state_d = vhal_pkg::ST_IDLE;
        end
      end
      vhal_pkg::ST_WALK: begin
        if (finish) begin
          state_d = vhal_pkg::ST_IDLE;
        end else if (go_dflt) begin
          state_d = vhal_pkg::ST_SEEK;
        end
      end
      default: begin
        state_d = vhal_pkg::ST_CLEAR;
      end
    endcase
  end

  // datapath and memory controls
  always_comb begin
    op_d       = op_q;
    addr_d     = addr_q;
    port_d     = port_q;
    srv_d      = srv_q;
    head_d     = head_q;
    cur_d      = cur_q;
    dhead_d    = dhead_q;
    used_d     = used_q;
    clr_d      = clr_q;
    in_dflt_d  = in_dflt_q;
    wild_vld_d = wild_vld_q;
    wild_srv_d = wild_srv_q;
    wild_cnt_d = wild_cnt_q;
    fold_start = 1'b0;
    bkt_we     = 1'b0;
    bkt_re     = 1'b0;
    bkt_waddr  = bucket;
    bkt_wdata  = used_q;
    ent_we     = 1'b0;
    ent_re     = 1'b0;
    ent_waddr  = cur_q[IW-1:0];
    ent_raddr  = cur_q[IW-1:0];
    ent_wdata  = ent;

    unique case (state_q)
      vhal_pkg::ST_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_q;
        bkt_wdata = EMPTY;
        clr_d     = clr_q + BW'(1);
      end
      vhal_pkg::ST_IDLE: begin
        if (start) begin
          op_d       = operation_i;
          addr_d     = address_i;
          port_d     = port_i;
          srv_d      = server_id_i;
          fold_start = 1'b1;
        end
      end
      vhal_pkg::ST_FOLD: begin
        if (fold_done) begin
          wild_vld_d = 1'b0;
          if (op_q == vhal_pkg::OP_INS_DFLT) begin
            cur_d     = dhead_q;
            in_dflt_d = 1'b1;
          end else begin
            bkt_re    = 1'b1;
            in_dflt_d = 1'b0;
          end
        end
      end
      vhal_pkg::ST_HEAD: begin
        head_d = bkt_rdata;
        cur_d  = bkt_rdata;
      end
      vhal_pkg::ST_SEEK: begin
        ent_re = !cur_empty;
      end
      vhal_pkg::ST_WALK: begin
        if (!exact) begin
          if (cand && !wild_vld_q) begin
            wild_vld_d = 1'b1;
            wild_srv_d = ent.srv;
            wild_cnt_d = ent.cnt;
          end
          if (!nxt_empty) begin
            ent_re    = 1'b1;
            ent_raddr = ent.nxt[IW-1:0];
            cur_d     = ent.nxt;
          end
        end else if (is_insert) begin
          // re-insert of an existing entry: address and port, or port alone on the default chain
          ent_we        = 1'b1;
          ent_wdata.srv = srv_q;
          ent_wdata.cnt = cnt_inc;
        end
      end
      default: begin
      end
    endcase

    if (go_dflt) begin
      cur_d      = dhead_q;
      in_dflt_d  = 1'b1;
      wild_vld_d = 1'b0;
    end

    if (do_add) begin
      ent_we         = 1'b1;
      ent_waddr      = used_q[IW-1:0];
      ent_wdata.addr = in_dflt_q ? '0 : addr_q;
      ent_wdata.port = port_q;
      ent_wdata.srv  = srv_q;
      ent_wdata.nxt  = in_dflt_q ? dhead_q : head_q;
      ent_wdata.cnt  = vhal_pkg::CNT_NEW;
      used_d         = used_q + LW'(1);
      if (in_dflt_q) begin
        dhead_d = used_q;
      end else begin
        bkt_we = 1'b1;
      end
    end
  end

  // result beat
  always_comb begin
    done_d    = finish;
    found_d   = found_q;
    res_srv_d = res_srv_q;
    nb_d      = nb_q;
    dflt_d    = dflt_q;
    status_d  = status_q;
    if (finish) begin
      found_d   = 1'b0;
      res_srv_d = '0;
      nb_d      = 1'b0;
      dflt_d    = 1'b0;
      status_d  = 1'b0;
      if (hit) begin
        found_d   = 1'b1;
        res_srv_d = is_insert ? srv_q : ent.srv;
        nb_d      = is_insert ? (cnt_inc >= vhal_pkg::CNT_SHARED)
                              : (ent.cnt >= vhal_pkg::CNT_SHARED);
        dflt_d    = in_dflt_q;
      end else if (is_insert) begin
        if (full) begin
          status_d = 1'b1;
        end else begin
          found_d   = 1'b1;
          res_srv_d = srv_q;
          dflt_d    = in_dflt_q;
        end
      end else if (wild_now) begin
        found_d   = 1'b1;
        res_srv_d = w_srv;
        nb_d      = w_cnt >= vhal_pkg::CNT_SHARED;
        dflt_d    = in_dflt_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= vhal_pkg::ST_CLEAR;
      clr_q      <= '0;
      used_q     <= '0;
      dhead_q    <= EMPTY;
      cur_q      <= EMPTY;
      in_dflt_q  <= 1'b0;
      wild_vld_q <= 1'b0;
      op_q       <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      used_q     <= used_d;
      dhead_q    <= dhead_d;
      cur_q      <= cur_d;
      in_dflt_q  <= in_dflt_d;
      wild_vld_q <= wild_vld_d;
      op_q       <= op_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    port_q     <= port_d;
    srv_q      <= srv_d;
    head_q     <= head_d;
    wild_srv_q <= wild_srv_d;
    wild_cnt_q <= wild_cnt_d;
    found_q    <= found_d;
    res_srv_q  <= res_srv_d;
    nb_q       <= nb_d;
    dflt_q     <= dflt_d;
    status_q   <= status_d;
  end

  assign busy             = state_q != vhal_pkg::ST_IDLE;
  assign done_o           = done_q;
  assign found_o          = found_q;
  assign matched_server_o = res_srv_q;
  assign name_based_o     = nb_q;
  assign from_default_o   = dflt_q;
  assign status_o         = status_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= EMPTY)
    else $error("entry fill count beyond store size");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> !found_o && $past(is_insert))
    else $error("store-full status on a non-insert or with a match");

  a_walk_linked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_walk |-> !cur_empty)
    else $error("chain walk on an empty link");

endmodule

`default_nettype wire

// ===== bench/virtual_host_address_lookup_tb.sv =====
// Self-checking bench for virtual_host_address_lookup: drives command beats,
// predicts every result with a scoreboard class and checks each done_o beat.
// Depends on vhal_pkg and the design files.
`timescale 1ns / 100ps

module virtual_host_address_lookup_tb;

  localparam int N_BUCKETS = 256;
  localparam int N_ENTRIES = 64;
  localparam int LINK_W = 7;
  localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(N_ENTRIES);
  // unused code, decodes as lookup
  localparam logic [vhal_pkg::OP_W-1:0] OP_SPARE = 2'd3;
  localparam int N_ITEMS = 900;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_CYCLES = 150;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                       found;
    logic [vhal_pkg::SRV_W-1:0] server;
    logic                       name_based;
    logic                       from_default;
    logic                       status;
  } vhost_result_t;

  class vhost_scoreboard;
    logic [LINK_W-1:0]           bucket_head [N_BUCKETS];
    logic [LINK_W-1:0]           dflt_head;
    logic [vhal_pkg::ADDR_W-1:0] ent_addr [N_ENTRIES];
    logic [vhal_pkg::PORT_W-1:0] ent_port [N_ENTRIES];
    logic [vhal_pkg::SRV_W-1:0]  ent_srv  [N_ENTRIES];
    logic [LINK_W-1:0]           ent_next [N_ENTRIES];
    logic [vhal_pkg::CNT_W-1:0]  ent_cnt  [N_ENTRIES];
    int unsigned                 used;
    vhost_result_t               pending_results [$];
    int unsigned                 mismatches;

    function new();
      foreach (bucket_head[i]) bucket_head[i] = EMPTY_LINK;
      dflt_head  = EMPTY_LINK;
      used       = 0;
      mismatches = 0;
    endfunction

    // exact address and port first, else first same-address entry with a zero port on
    // either side
    function int seek_bucket(int b, logic [vhal_pkg::ADDR_W-1:0] addr,
                             logic [vhal_pkg::PORT_W-1:0] port);
      int idx;
      int wild;
      idx  = bucket_head[b];
      wild = N_ENTRIES;
      for (int steps = 0; steps < N_ENTRIES && idx < N_ENTRIES; steps++) begin
        if (ent_addr[idx] == addr) begin
          if (ent_port[idx] == port) return idx;
          if (wild == N_ENTRIES && (ent_port[idx] == '0 || port == '0)) wild = idx;
        end
        idx = ent_next[idx];
      end
      return wild;
    endfunction

    function int seek_default(logic [vhal_pkg::PORT_W-1:0] port);
      int idx;
      int wild;
      idx  = dflt_head;
      wild = N_ENTRIES;
      for (int steps = 0; steps < N_ENTRIES && idx < N_ENTRIES; steps++) begin
        if (ent_port[idx] == port) return idx;
        if (wild == N_ENTRIES && ent_port[idx] == '0) wild = idx;
        idx = ent_next[idx];
      end
      return wild;
    endfunction

    function vhost_result_t hit(int idx, bit dflt);
      vhost_result_t res;
      res              = '0;
      res.found        = 1'b1;
      res.server       = ent_srv[idx];
      res.name_based   = (ent_cnt[idx] >= vhal_pkg::CNT_SHARED);
      res.from_default = dflt;
      return res;
    endfunction

    function void note_command(logic [vhal_pkg::OP_W-1:0] op,
                               logic [vhal_pkg::ADDR_W-1:0] addr,
                               logic [vhal_pkg::PORT_W-1:0] port,
                               logic [vhal_pkg::SRV_W-1:0] srv);
      vhost_result_t res;
      logic [vhal_pkg::ADDR_W-1:0] h;
      int b;
      int idx;
      bit dflt;
      res  = '0;
      h    = addr ^ (addr >> 16);
      b    = ((h >> 8) ^ h) % N_BUCKETS;
      dflt = (op == vhal_pkg::OP_INS_DFLT);
      if (op == vhal_pkg::OP_INS_ADDR || dflt) begin
        idx = dflt ? seek_default(port) : seek_bucket(b, addr, port);
        if (idx < N_ENTRIES && ent_port[idx] == port) begin
          ent_srv[idx] = srv;
          if (ent_cnt[idx] != vhal_pkg::CNT_MAX) ent_cnt[idx] = ent_cnt[idx] + 1'b1;
          res = hit(idx, dflt);
        end else if (used >= N_ENTRIES) begin
          res.status = 1'b1;
        end else begin
          idx           = used;
          used++;
          ent_addr[idx] = dflt ? '0 : addr;
          ent_port[idx] = port;
          ent_srv[idx]  = srv;
          ent_cnt[idx]  = vhal_pkg::CNT_NEW;
          if (dflt) begin
            ent_next[idx] = dflt_head;
            dflt_head     = LINK_W'(idx);
          end else begin
            ent_next[idx]  = bucket_head[b];
            bucket_head[b] = LINK_W'(idx);
          end
          res = hit(idx, dflt);
        end
      end else begin
        idx = seek_bucket(b, addr, port);
        if (idx < N_ENTRIES) begin
          res = hit(idx, 1'b0);
        end else begin
          idx = seek_default(port);
          if (idx < N_ENTRIES) res = hit(idx, 1'b1);
        end
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(vhost_result_t got);
      vhost_result_t want;
      if (pending_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display({"%0t: result beat with nothing outstanding: ",
                    "found=%0d srv=%0d nb=%0d dflt=%0d st=%0d"},
                   $realtime, got.found, got.server, got.name_based, got.from_default,
                   got.status);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.found !== want.found || got.server !== want.server ||
          got.name_based !== want.name_based || got.from_default !== want.from_default ||
          got.status !== want.status) begin
        if (mismatches < MAX_REPORTS)
          $display({"%0t: mismatch exp found=%0d srv=%0d nb=%0d dflt=%0d st=%0d, ",
                    "got found=%0d srv=%0d nb=%0d dflt=%0d st=%0d"},
                   $realtime, want.found, want.server, want.name_based, want.from_default,
                   want.status, got.found, got.server, got.name_based, got.from_default,
                   got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic [vhal_pkg::OP_W-1:0]   operation_i;
  logic [vhal_pkg::ADDR_W-1:0] address_i;
  logic [vhal_pkg::PORT_W-1:0] port_i;
  logic [vhal_pkg::SRV_W-1:0]  server_id_i;
  logic                        done_o;
  logic                        found_o;
  logic [vhal_pkg::SRV_W-1:0]  matched_server_o;
  logic                        name_based_o;
  logic                        from_default_o;
  logic                        status_o;

  vhost_scoreboard             sb;
  int                          idle_cycles = 0;
  logic [vhal_pkg::ADDR_W-1:0] addr_pool [32];
  logic [vhal_pkg::PORT_W-1:0] port_pool [8];

  virtual_host_address_lookup #(
    .BUCKETS(N_BUCKETS),
    .ENTRIES(N_ENTRIES)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .address_i       (address_i),
    .port_i          (port_i),
    .server_id_i     (server_id_i),
    .done_o          (done_o),
    .found_o         (found_o),
    .matched_server_o(matched_server_o),
    .name_based_o    (name_based_o),
    .from_default_o  (from_default_o),
    .status_o        (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sample at the edge: every value seen here is the one from the cycle just ended
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      sb.note_command(operation_i, address_i, port_i, server_id_i);
      idle_cycles <= 0;
    end else if (rst_ni && done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_ni && done_o)
      sb.check_result({found_o, matched_server_o, name_based_o, from_default_o, status_o});
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  // called at a rising edge; returns at the edge that accepted the beat or after the gap
  task automatic drive_beat(input logic [vhal_pkg::OP_W-1:0] op,
                            input logic [vhal_pkg::ADDR_W-1:0] addr,
                            input logic [vhal_pkg::PORT_W-1:0] port,
                            input logic [vhal_pkg::SRV_W-1:0] srv,
                            input bit allow_idle);
    int gap;
    start       <= 1'b1;
    operation_i <= op;
    address_i   <= addr;
    port_i      <= port;
    server_id_i <= srv;
    do @(posedge clk_i); while (busy);
    gap = 0;
    if (allow_idle && $urandom_range(99) < 27) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start       <= 1'b0;
      operation_i <= vhal_pkg::OP_W'($urandom);
      address_i   <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drive_random(input bit allow_idle);
    int r;
    logic [vhal_pkg::OP_W-1:0] op;
    r = $urandom_range(99);
    if (r < 15) begin
      drive_beat(vhal_pkg::OP_W'($urandom_range(3)), $urandom,
                 vhal_pkg::PORT_W'($urandom), vhal_pkg::SRV_W'($urandom), allow_idle);
    end else begin
      r  = $urandom_range(99);
      op = (r < 50) ? vhal_pkg::OP_LOOKUP :
           (r < 82) ? vhal_pkg::OP_INS_ADDR : vhal_pkg::OP_INS_DFLT;
      drive_beat(op, addr_pool[$urandom_range(31)], port_pool[$urandom_range(7)],
                 vhal_pkg::SRV_W'($urandom), allow_idle);
    end
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    start       = 1'b0;
    operation_i = '0;
    address_i   = '0;
    port_i      = '0;
    server_id_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // addresses that share a bucket: byte rotations keep the XOR fold
    for (int i = 0; i < 12; i++) addr_pool[i] = $urandom;
    for (int i = 0; i < 12; i++) addr_pool[12+i] = {addr_pool[i][23:0], addr_pool[i][31:24]};
    for (int i = 0; i < 4; i++) addr_pool[24+i] = {addr_pool[i][15:0], addr_pool[i][31:16]};
    addr_pool[28] = '0;
    addr_pool[29] = '1;
    addr_pool[30] = 32'hC0A8_0001;
    addr_pool[31] = 32'h0100_A8C0;
    port_pool = '{16'd0, 16'd80, 16'd443, 16'd8080, 16'd22, 16'hFFFF,
                  vhal_pkg::PORT_W'($urandom), vhal_pkg::PORT_W'($urandom)};

    // directed: empty table, zero address, wildcard ports, default chain, updates
    drive_beat(vhal_pkg::OP_LOOKUP,   32'h0000_0000, 16'd0,    8'd0,   1'b1);
    drive_beat(vhal_pkg::OP_LOOKUP,   32'hFFFF_FFFF, 16'hFFFF, 8'hFF,  1'b1);
    drive_beat(vhal_pkg::OP_INS_ADDR, 32'h0000_0000, 16'd80,   8'd0,   1'b1);
    drive_beat(vhal_pkg::OP_LOOKUP,   32'h0000_0000, 16'd80,   8'd0,   1'b1);
    drive_beat(vhal_pkg::OP_INS_DFLT, 32'hFFFF_FFFF, 16'd0,    8'hFF,  1'b1);
    drive_beat(vhal_pkg::OP_LOOKUP,   32'h0102_0304, 16'd22,   8'd0,   1'b1);
    drive_beat(vhal_pkg::OP_INS_DFLT, 32'h0000_0000, 16'd22,   8'd7,   1'b1);
    drive_beat(vhal_pkg::OP_LOOKUP,   32'h0102_0304, 16'd22,   8'd0,   1'b1);
    drive_beat(vhal_pkg::OP_INS_ADDR, 32'hC0A8_0001, 16'd0,    8'd10,  1'b1);
    drive_beat(vhal_pkg::OP_INS_ADDR, 32'hC0A8_0001, 16'd443,  8'd11,  1'b1);
    drive_beat(vhal_pkg::OP_LOOKUP,   32'hC0A8_0001, 16'd443,  8'd0,   1'b1);
    drive_beat(vhal_pkg::OP_LOOKUP,   32'hC0A8_0001, 16'd8080, 8'd0,   1'b1);
    drive_beat(vhal_pkg::OP_INS_ADDR, 32'h0100_A8C0, 16'd443,  8'd12,  1'b1);
    drive_beat(vhal_pkg::OP_LOOKUP,   32'h0100_A8C0, 16'd0,    8'd0,   1'b1);
    drive_beat(vhal_pkg::OP_INS_ADDR, 32'hC0A8_0001, 16'd443,  8'd20,  1'b1);
    drive_beat(vhal_pkg::OP_INS_ADDR, 32'hC0A8_0001, 16'd443,  8'd21,  1'b1);
    drive_beat(vhal_pkg::OP_INS_ADDR, 32'hC0A8_0001, 16'd443,  8'd22,  1'b1);
    drive_beat(vhal_pkg::OP_INS_DFLT, 32'h1234_5678, 16'd22,   8'd99,  1'b1);
    drive_beat(OP_SPARE,              32'hC0A8_0001, 16'd443,  8'd0,   1'b1);
    drive_beat(OP_SPARE,              32'h0A0B_0C0D, 16'd9999, 8'd0,   1'b1);
    drive_beat(vhal_pkg::OP_INS_ADDR, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF,  1'b1);
    drive_beat(vhal_pkg::OP_LOOKUP,   32'hFFFF_FFFF, 16'hFFFF, 8'd0,   1'b1);
    drive_beat(vhal_pkg::OP_LOOKUP,   32'hFFFF_FFFF, 16'd0,    8'd0,   1'b1);

    for (int n = 0; n < N_ITEMS; n++) begin
      if (n == N_ITEMS / 2) begin
        // drain: hold off until every outstanding beat has come back
        start <= 1'b0;
        do @(posedge clk_i); while (sb.pending_results.size() != 0);
      end
      drive_random(!(n >= 250 && n < 400));
    end
    start <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
